### sv/costmap_obstacle_decay_engine_defines.svh
// assertion macros for the costmap obstacle decay engine
// used by the top level only; the bodies are empty for synthesis
`ifndef COSTMAP_OBSTACLE_DECAY_ENGINE_DEFINES_SVH
`define COSTMAP_OBSTACLE_DECAY_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define COD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define COD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define COD_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define COD_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

### sv/cod_pkg.sv
// shared types, codes and window helpers of the costmap obstacle decay engine
// no dependencies
package cod_pkg;

    localparam logic [7:0] COST_UNKNOWN  = 8'd255;
    localparam logic [7:0] COST_INFLATED = 8'd254;

    // command codes on the input port
    localparam logic [2:0] CMD_LOAD    = 3'd0;
    localparam logic [2:0] CMD_INFLATE = 3'd1;
    localparam logic [2:0] CMD_OBSERVE = 3'd2;
    localparam logic [2:0] CMD_TICK    = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_NEW   = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_COUNT = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_OBSTACLE = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_MAX_Z    = 3'd4;

    // queue depths between the parts
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_INFLATE,
        OP_OBSERVE,
        OP_TICK,
        OP_READ,
        OP_NOP
    } op_t;

    // effective configuration, already clamped
    typedef struct packed {
        logic [6:0]        width;
        logic [6:0]        height;
        logic [7:0]        obstacle;
        logic [1:0]        radius;
        logic signed [15:0] max_z;
    } cfg_t;

    // classified command between front and back
    typedef struct packed {
        op_t        op;
        logic [5:0] x;
        logic [5:0] y;
        logic       in_grid;
        logic       high;
        logic [7:0] value;
        logic [7:0] elapsed;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] cell_index;
        logic [12:0] deletion_count;
        logic [7:0]  cost_value;
        logic        out_of_range;
        logic        last;
    } res_t;

    // one stored map cell
    typedef struct packed {
        logic       snap;
        logic       dyn;
        logic [7:0] wd;
        logic [7:0] live;
        logic [7:0] stat;
    } cell_t;

    // low edge of a square window
    function automatic logic [6:0] win_lo(input logic [6:0] c, input logic [1:0] r);
        win_lo = (c > 7'(r)) ? c - 7'(r) : 7'd0;
    endfunction

    // high edge of a square window, clipped to the grid
    function automatic logic [6:0] win_hi(input logic [6:0] c, input logic [1:0] r,
                                          input logic [6:0] lim);
        logic [7:0] s;
        s = {1'b0, c} + 8'(r);
        win_hi = (s > ({1'b0, lim} - 8'd1)) ? lim - 7'd1 : s[6:0];
    endfunction

endpackage

### sv/cod_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module cod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/cod_fifo.sv
// small register queue used between the parts of the engine
// no dependencies
module cod_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### sv/cod_front.sv
// front part: takes input items, decodes the command and classifies the cell
// depends on cod_pkg
module cod_front
    import cod_pkg::*;
(
    input  cfg_t        cfg,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  command,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [15:0] point_z,
    input  logic [7:0]  static_value,
    input  logic [7:0]  elapsed_ticks,
    input  logic        clearing,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_data
);

    op_t  op;

    // command decode
    always_comb
    begin
        unique case (command)
            CMD_LOAD:    op = OP_LOAD;
            CMD_INFLATE: op = OP_INFLATE;
            CMD_OBSERVE: op = OP_OBSERVE;
            CMD_TICK:    op = OP_TICK;
            CMD_READ:    op = OP_READ;
            default:     op = OP_NOP;
        endcase
    end

    // classify and clamp
    always_comb
    begin
        q_data.op      = op;
        q_data.x       = cell_x;
        q_data.y       = cell_y;
        q_data.in_grid = ({1'b0, cell_x} < cfg.width) && ({1'b0, cell_y} < cfg.height);
        q_data.high    = $signed(point_z) > cfg.max_z;
        q_data.value   = ((static_value > cfg.obstacle) && (static_value != COST_UNKNOWN))
                         ? cfg.obstacle : static_value;
        q_data.elapsed = elapsed_ticks;
    end

    assign full   = q_full || clearing;
    assign q_push = push && !full;

endmodule

### sv/cod_back.sv
// back part: sequencer over the cell memory that carries out each command
// depends on cod_pkg and cod_ram
module cod_back
    import cod_pkg::*;
#(
    parameter int CELLS  = 4096,
    parameter int WD_MAX = 255
) (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_empty,
    input  cmd_t  q_data,
    output logic  q_pop,
    input  logic  res_full,
    output logic  res_push,
    output res_t  res_data,
    output logic  clearing
);

    localparam int AW   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNTW = $clog2(CELLS + 1);
    localparam logic [7:0] WDM = 8'(WD_MAX);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DEC   = 6'b000100,
        S_CRD   = 6'b001000,
        S_CWR   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        A_LOAD,
        A_READ,
        A_SNAP,
        A_SCAN,
        A_INFL,
        A_CENT,
        A_OBSQ,
        A_TICK
    } act_t;

    state_t          state_reg, state_next;
    act_t            act_reg, act_next;
    cmd_t            cmd_reg, cmd_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   sweep_reg, sweep_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [6:0]      ci_reg, ci_next, cj_reg, cj_next;
    logic [6:0]      sx_reg, sx_next, sy_reg, sy_next;
    logic [6:0]      x0_reg, x0_next, x1_reg, x1_next;
    logic [6:0]      y0_reg, y0_next, y1_reg, y1_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    res_t            res_reg, res_next;

    logic [6:0]      ma, mb;
    logic [13:0]     lin;
    logic [AW-1:0]   rd_addr;
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr;
    cell_t           ram_wdata, cur;
    logic [$bits(cell_t)-1:0] ram_rdata;
    logic            fresh, sq_end, scan_end, sweep_end;
    logic [7:0]      touch_state;
    cell_t           tw, tk;
    logic            removed;

    cod_ram #(
        .WIDTH ($bits(cell_t)),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign cur      = cell_t'(ram_rdata);
    assign clearing = (state_reg == S_CLEAR);

    // shared index multiplier: column plus row times width
    always_comb
    begin
        if (state_reg == S_DEC)
        begin
            ma = {1'b0, cmd_reg.x};
            mb = {1'b0, cmd_reg.y};
        end
        else if (act_reg == A_SCAN)
        begin
            ma = sx_reg;
            mb = sy_reg;
        end
        else
        begin
            ma = ci_reg;
            mb = cj_reg;
        end
        lin = 14'(ma) + 14'(mb) * 14'(cfg.width);
    end

    // read address by activity
    always_comb
    begin
        case (act_reg) inside
            A_LOAD, A_READ, A_CENT: rd_addr = idx_reg;
            A_SNAP, A_TICK:         rd_addr = sweep_reg;
            default:                rd_addr = AW'(lin);
        endcase
    end

    assign sweep_end = (sweep_reg == AW'(CELLS - 1));
    assign sq_end    = (ci_reg == x1_reg) && (cj_reg == y1_reg);
    assign scan_end  = (sx_reg == cfg.width - 7'd1) && (sy_reg == cfg.height - 7'd1);

    // observation touch of one cell
    always_comb
    begin
        touch_state = (act_reg == A_CENT) ? cfg.obstacle : COST_INFLATED;
        fresh       = (cur.wd == 8'd0) && (cur.stat != cfg.obstacle);
        tw          = cur;
        if (fresh)
        begin
            tw.dyn = 1'b1;
        end
        if (touch_state == cfg.obstacle)
        begin
            tw.live = cfg.obstacle;
        end
        if ((cur.wd < WDM) && (cur.stat != cfg.obstacle))
        begin
            tw.live = touch_state;
        end
        tw.wd = WDM;
    end

    // watchdog ageing of one cell
    always_comb
    begin
        tk      = cur;
        removed = 1'b0;
        if (cur.dyn)
        begin
            if (cur.wd == WDM)
            begin
                tk.wd = WDM - 8'd1;
            end
            else if (cur.wd <= cmd_reg.elapsed)
            begin
                tk.wd   = 8'd0;
                tk.dyn  = 1'b0;
                tk.live = cur.stat;
                removed = 1'b1;
            end
            else
            begin
                tk.wd = cur.wd - cmd_reg.elapsed;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        sweep_next = sweep_reg;
        addr_next  = addr_reg;
        ci_next    = ci_reg;
        cj_next    = cj_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        y0_next    = y0_reg;
        y1_next    = y1_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        q_pop      = 1'b0;
        res_push   = 1'b0;
        res_data   = res_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wdata  = cur;

        unique case (state_reg)
            // wipe the whole memory after reset
            S_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_end)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    state_next = S_DEC;
                end
            end

            // index, window and first step of the command
            S_DEC:
            begin
                idx_next = AW'(lin);
                x0_next  = win_lo({1'b0, cmd_reg.x}, cfg.radius);
                x1_next  = win_hi({1'b0, cmd_reg.x}, cfg.radius, cfg.width);
                y0_next  = win_lo({1'b0, cmd_reg.y}, cfg.radius);
                y1_next  = win_hi({1'b0, cmd_reg.y}, cfg.radius, cfg.height);
                res_next = '{kind: KIND_DONE, cell_index: 12'd0, deletion_count: 13'd0,
                             cost_value: 8'd0, out_of_range: !cmd_reg.in_grid, last: 1'b1};
                state_next = S_EMIT;
                unique case (cmd_reg.op)
                    OP_LOAD:
                    begin
                        if (cmd_reg.in_grid)
                        begin
                            act_next   = A_LOAD;
                            state_next = S_CRD;
                        end
                    end
                    OP_READ:
                    begin
                        res_next.kind = KIND_READ;
                        if (cmd_reg.in_grid)
                        begin
                            act_next   = A_READ;
                            state_next = S_CRD;
                        end
                    end
                    OP_OBSERVE:
                    begin
                        if (cmd_reg.high)
                        begin
                            res_next.out_of_range = 1'b0;
                            res_next.cell_index   = cmd_reg.in_grid ? 12'(lin) : 12'd0;
                        end
                        else if (cmd_reg.in_grid)
                        begin
                            act_next   = A_CENT;
                            state_next = S_CRD;
                        end
                    end
                    OP_TICK:
                    begin
                        res_next.out_of_range = 1'b0;
                        sweep_next = '0;
                        cnt_next   = '0;
                        act_next   = A_TICK;
                        state_next = S_CRD;
                    end
                    OP_INFLATE:
                    begin
                        res_next.out_of_range = 1'b0;
                        sweep_next = '0;
                        act_next   = A_SNAP;
                        state_next = S_CRD;
                    end
                    default:
                    begin
                        res_next.out_of_range = 1'b0;
                    end
                endcase
            end

            S_CRD:
            begin
                ram_re     = 1'b1;
                addr_next  = rd_addr;
                state_next = S_CWR;
            end

            S_CWR:
            begin
                state_next = S_CRD;
                case (act_reg) inside
                    A_LOAD:
                    begin
                        ram_we         = 1'b1;
                        ram_wdata.stat = cmd_reg.value;
                        if (cur.wd == 8'd0)
                        begin
                            ram_wdata.live = cmd_reg.value;
                        end
                        res_next.cell_index = 12'(idx_reg);
                        state_next          = S_EMIT;
                    end
                    A_READ:
                    begin
                        res_next.cell_index = 12'(idx_reg);
                        res_next.cost_value = cur.live;
                        state_next          = S_EMIT;
                    end
                    A_SNAP:
                    begin
                        ram_we         = 1'b1;
                        ram_wdata.snap = (cur.stat == cfg.obstacle);
                        sweep_next     = sweep_reg + 1'b1;
                        if (sweep_end)
                        begin
                            sweep_next = '0;
                            sx_next    = '0;
                            sy_next    = '0;
                            act_next   = A_SCAN;
                        end
                    end
                    A_SCAN:
                    begin
                        if (cur.snap)
                        begin
                            x0_next  = win_lo(sx_reg, cfg.radius);
                            x1_next  = win_hi(sx_reg, cfg.radius, cfg.width);
                            y0_next  = win_lo(sy_reg, cfg.radius);
                            y1_next  = win_hi(sy_reg, cfg.radius, cfg.height);
                            ci_next  = win_lo(sx_reg, cfg.radius);
                            cj_next  = win_lo(sy_reg, cfg.radius);
                            act_next = A_INFL;
                        end
                        else if (scan_end)
                        begin
                            state_next = S_EMIT;
                        end
                        else if (sx_reg == cfg.width - 7'd1)
                        begin
                            sx_next = '0;
                            sy_next = sy_reg + 7'd1;
                        end
                        else
                        begin
                            sx_next = sx_reg + 7'd1;
                        end
                    end
                    A_INFL:
                    begin
                        if (cur.stat != cfg.obstacle)
                        begin
                            ram_we         = 1'b1;
                            ram_wdata.stat = COST_INFLATED;
                            if (cur.wd == 8'd0)
                            begin
                                ram_wdata.live = COST_INFLATED;
                            end
                        end
                        if (!sq_end)
                        begin
                            if (cj_reg == y1_reg)
                            begin
                                ci_next = ci_reg + 7'd1;
                                cj_next = y0_reg;
                            end
                            else
                            begin
                                cj_next = cj_reg + 7'd1;
                            end
                        end
                        else
                        begin
                            // back to the scan, one past this obstacle
                            act_next = A_SCAN;
                            if (scan_end)
                            begin
                                state_next = S_EMIT;
                            end
                            else if (sx_reg == cfg.width - 7'd1)
                            begin
                                sx_next = '0;
                                sy_next = sy_reg + 7'd1;
                            end
                            else
                            begin
                                sx_next = sx_reg + 7'd1;
                            end
                        end
                    end
                    A_CENT, A_OBSQ:
                    begin
                        if (fresh && res_full)
                        begin
                            state_next = S_CWR;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = tw;
                            if (fresh)
                            begin
                                res_push = 1'b1;
                                res_data = '{kind: KIND_NEW, cell_index: 12'(addr_reg),
                                             deletion_count: 13'd0, cost_value: 8'd0,
                                             out_of_range: 1'b0, last: 1'b0};
                            end
                            if (act_reg == A_CENT)
                            begin
                                act_next = A_OBSQ;
                                ci_next  = x0_reg;
                                cj_next  = y0_reg;
                            end
                            else if (sq_end)
                            begin
                                res_next.cell_index = 12'(idx_reg);
                                state_next          = S_EMIT;
                            end
                            else if (cj_reg == y1_reg)
                            begin
                                ci_next = ci_reg + 7'd1;
                                cj_next = y0_reg;
                            end
                            else
                            begin
                                cj_next = cj_reg + 7'd1;
                            end
                        end
                    end
                    default:
                    begin
                        // tick sweep over the whole store
                        ram_we     = 1'b1;
                        ram_wdata  = tk;
                        cnt_next   = cnt_reg + CNTW'(removed);
                        sweep_next = sweep_reg + 1'b1;
                        if (sweep_end)
                        begin
                            sweep_next              = '0;
                            res_next.kind           = KIND_COUNT;
                            res_next.deletion_count = 13'(cnt_reg + CNTW'(removed));
                            state_next              = S_EMIT;
                        end
                    end
                endcase
            end

            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res_data   = res_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            act_reg   <= A_LOAD;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            sweep_reg <= sweep_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        addr_reg <= addr_next;
        ci_reg   <= ci_next;
        cj_reg   <= cj_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        x0_reg   <= x0_next;
        x1_reg   <= x1_next;
        y0_reg   <= y0_next;
        y1_reg   <= y1_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

endmodule

### sv/costmap_obstacle_decay_engine.sv
// costmap obstacle decay engine: load and read act on one in-grid cell, observe
// on an in-grid cell at or below max_z and its neighbourhood, tick sweeps every
// stored cell, inflate sweeps the store, scans the grid and marks the cells
// around each obstacle; one command at a time, two more wait in the queue, so
// throughput equals latency; result stalls add. reset: async active low, then
// a clearing pass over every stored cell holds full high.
`include "costmap_obstacle_decay_engine_defines.svh"

module costmap_obstacle_decay_engine
    import cod_pkg::*;
#(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int WATCHDOG_MAX = 255,
    parameter int MAX_RADIUS   = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  command,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [15:0] point_z,
    input  logic [7:0]  static_value,
    input  logic [7:0]  elapsed_ticks,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [11:0] cell_index,
    output logic [12:0] deletion_count,
    output logic [7:0]  cost_value,
    output logic        out_of_range,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;

    logic [6:0]  width_reg, width_next;
    logic [6:0]  height_reg, height_next;
    logic [7:0]  obstacle_reg, obstacle_next;
    logic [1:0]  radius_reg, radius_next;
    logic [15:0] max_z_reg, max_z_next;
    cfg_t        cfg;

    logic        q_full, q_empty, q_push, q_pop;
    cmd_t        q_wdata;
    logic [$bits(cmd_t)-1:0] q_rdata;
    logic        res_full, res_push;
    res_t        res_wdata, res_out;
    logic [$bits(res_t)-1:0] res_rdata;
    logic        clearing;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        obstacle_next = obstacle_reg;
        radius_next   = radius_reg;
        max_z_next    = max_z_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WIDTH:    width_next    = cfg_data[6:0];
                REG_HEIGHT:   height_next   = cfg_data[6:0];
                REG_OBSTACLE: obstacle_next = cfg_data[7:0];
                REG_RADIUS:   radius_next   = cfg_data[1:0];
                REG_MAX_Z:    max_z_next    = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 7'd64;
            height_reg   <= 7'd64;
            obstacle_reg <= 8'd253;
            radius_reg   <= 2'd1;
            max_z_reg    <= 16'd2000;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            obstacle_reg <= obstacle_next;
            radius_reg   <= radius_next;
            max_z_reg    <= max_z_next;
        end
    end

    // clamped view of the registers
    always_comb
    begin
        if (width_reg == 7'd0)
            cfg.width = 7'd1;
        else if (32'(width_reg) > MAX_WIDTH)
            cfg.width = 7'(MAX_WIDTH);
        else
            cfg.width = width_reg;
        if (height_reg == 7'd0)
            cfg.height = 7'd1;
        else if (32'(height_reg) > MAX_HEIGHT)
            cfg.height = 7'(MAX_HEIGHT);
        else
            cfg.height = height_reg;
        cfg.obstacle = obstacle_reg;
        cfg.radius   = (32'(radius_reg) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius_reg;
        cfg.max_z    = $signed(max_z_reg);
    end

    cod_front u_front (
        .cfg           (cfg),
        .push          (push),
        .full          (full),
        .command       (command),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .point_z       (point_z),
        .static_value  (static_value),
        .elapsed_ticks (elapsed_ticks),
        .clearing      (clearing),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    // command queue between front and back
    cod_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    cod_back #(
        .CELLS  (CELLS),
        .WD_MAX (WATCHDOG_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_data   (cmd_t'(q_rdata)),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_wdata),
        .clearing (clearing)
    );

    // result queue toward the output side
    cod_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_out        = res_t'(res_rdata);
    assign kind           = res_out.kind;
    assign cell_index     = res_out.cell_index;
    assign deletion_count = res_out.deletion_count;
    assign cost_value     = res_out.cost_value;
    assign out_of_range   = res_out.out_of_range;
    assign last           = res_out.last;

    // checks
    `COD_ASSERT_IMP(a_res_no_overflow, clk, rst_n, res_push, !res_full)
    `COD_ASSERT_IMP(a_clear_blocks_input, clk, rst_n, clearing, full)
    `COD_ASSERT_IMP(a_pop_needs_item, clk, rst_n, q_pop, !q_empty)
    `COD_ASSERT_NXT(a_item_queued, clk, rst_n, push && !full, !q_empty)

endmodule
